### hdl/cac_pkg.sv
// shared types and constants of the credit admission controller
`default_nettype none

package cac_pkg;

	// field widths
	localparam int CHARGE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int LEVEL_W  = 40;
	localparam int STAT_W   = 64;
	localparam int CFG_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int REG_IDX_W = 3;
	localparam int EV_COUNT = 10;

	// request type codes
	localparam logic [3:0] REQ_RESERVE_Q     = 4'd0;
	localparam logic [3:0] REQ_RELEASE_UNPUB = 4'd1;
	localparam logic [3:0] REQ_ACTIVATE      = 4'd2;
	localparam logic [3:0] REQ_REQUEUE       = 4'd3;
	localparam logic [3:0] REQ_RELEASE       = 4'd4;
	localparam logic [3:0] REQ_RESERVE_RESP  = 4'd5;
	localparam logic [3:0] REQ_RELEASE_RESP  = 4'd6;
	localparam logic [3:0] REQ_RATE_LIMIT    = 4'd7;
	localparam logic [3:0] REQ_READ_STAT     = 4'd8;

	// request resource states
	localparam logic [1:0] RS_NONE   = 2'd0;
	localparam logic [1:0] RS_QUEUED = 2'd1;
	localparam logic [1:0] RS_ACTIVE = 2'd2;
	localparam logic [1:0] RS_UNUSED = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	// statistic indexes
	localparam logic [4:0] STAT_QCOUNT    = 5'd0;
	localparam logic [4:0] STAT_QBYTES    = 5'd1;
	localparam logic [4:0] STAT_ACOUNT    = 5'd2;
	localparam logic [4:0] STAT_ABYTES    = 5'd3;
	localparam logic [4:0] STAT_RBYTES    = 5'd4;
	localparam logic [4:0] STAT_HW_QCOUNT = 5'd5;
	localparam logic [4:0] STAT_HW_QBYTES = 5'd6;
	localparam logic [4:0] STAT_HW_ACOUNT = 5'd7;
	localparam logic [4:0] STAT_HW_ABYTES = 5'd8;
	localparam logic [4:0] STAT_HW_RBYTES = 5'd9;
	localparam logic [4:0] STAT_EV_FIRST  = 5'd10;
	localparam logic [4:0] STAT_EV_LAST   = 5'd19;

	// event counter slots
	localparam int EV_REJ_REQ      = 0;
	localparam int EV_REJ_QCOUNT   = 1;
	localparam int EV_REJ_QBYTES   = 2;
	localparam int EV_ADMIT_REJ    = 3;
	localparam int EV_REJ_ACTIVE   = 4;
	localparam int EV_REJ_RESP     = 5;
	localparam int EV_RETRIED      = 6;
	localparam int EV_COMPLETED    = 7;
	localparam int EV_CANCELED     = 8;
	localparam int EV_RATE_LIMITED = 9;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MAX_REQUEST_BYTES  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_QUEUED_COUNT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_QUEUED_BYTES   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ACTIVE_BYTES   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RESPONSE_BYTES = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] RST_MAX_REQUEST_BYTES  = 32'd1048576;
	localparam logic [CFG_W-1:0] RST_MAX_QUEUED_COUNT   = 32'd256;
	localparam logic [CFG_W-1:0] RST_MAX_QUEUED_BYTES   = 32'd16777216;
	localparam logic [CFG_W-1:0] RST_MAX_ACTIVE_BYTES   = 32'd16777216;
	localparam logic [CFG_W-1:0] RST_MAX_RESPONSE_BYTES = 32'd8388608;

	// classified operation carried from front to back
	typedef enum logic [3:0] {
		OP_INVALID,
		OP_NOP,
		OP_RESERVE_Q,
		OP_RELEASE_UNPUB,
		OP_ACTIVATE,
		OP_REQUEUE,
		OP_RELEASE_REQ,
		OP_RESERVE_RESP,
		OP_RELEASE_RESP,
		OP_RATE_LIMIT,
		OP_READ_STAT
	} op_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_request_bytes;
		logic [CFG_W-1:0] max_queued_count;
		logic [CFG_W-1:0] max_queued_bytes;
		logic [CFG_W-1:0] max_active_bytes;
		logic [CFG_W-1:0] max_response_bytes;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [CHARGE_W-1:0] charge;
		logic [1:0]          echo_state;
		logic                from_queued;
		logic                completion;
		logic                cancel;
		logic [4:0]          stat_index;
		logic                req_too_big;
		logic                resp_too_big;
	} item_t;

endpackage

`default_nettype wire

### hdl/credit_admission_controller.sv
// credit admission controller top level: config port, front, queue and back
// a request beat is written into the operation queue, and its result is registered when the back end takes it
// throughput: one request per cycle while results do not stall, set by the back end update
// the operation queue absorbs up to QUEUE_DEPTH requests while results stall
// reset: levels, high-water marks and event counters clear, limits take defaults
`default_nettype none

module credit_admission_controller #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cac_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [cac_pkg::CFG_W-1:0]    pwdata,
	output logic      [cac_pkg::CFG_W-1:0]    prdata,
	output logic                              pready,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [3:0]                   req_type,
	input  wire logic [cac_pkg::CHARGE_W-1:0] charge,
	input  wire logic [1:0]                   request_state,
	input  wire logic                         count_completion,
	input  wire logic                         cancel_flag,
	input  wire logic [4:0]                   stat_index,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output logic [1:0]                        status,
	output logic [1:0]                        new_request_state,
	output logic [cac_pkg::STAT_W-1:0]        stat_value
);
	import cac_pkg::*;

	cfg_t  cfg;
	item_t front_item;
	item_t head_item;
	logic  front_push;
	logic  queue_full;
	logic  queue_empty;
	logic  back_pop;

	cac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cac_front u_front (
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.req_type         (req_type),
		.charge           (charge),
		.request_state    (request_state),
		.count_completion (count_completion),
		.cancel_flag      (cancel_flag),
		.stat_index       (stat_index),
		.cfg              (cfg),
		.queue_full       (queue_full),
		.push             (front_push),
		.item             (front_item)
	);

	cac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (back_pop),
		.head      (head_item),
		.empty     (queue_empty)
	);

	cac_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.head              (head_item),
		.empty             (queue_empty),
		.pop               (back_pop),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.status            (status),
		.new_request_state (new_request_state),
		.stat_value        (stat_value)
	);

endmodule

`default_nettype wire

### hdl/cac_regs.sv
// configuration register file with apb-style access
`default_nettype none

module cac_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cac_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cac_pkg::CFG_W-1:0]  pwdata,
	output logic      [cac_pkg::CFG_W-1:0]  prdata,
	output logic                            pready,
	output cac_pkg::cfg_t                   cfg
);
	import cac_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_beat;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_beat = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_request_bytes  <= RST_MAX_REQUEST_BYTES;
			cfg_q.max_queued_count   <= RST_MAX_QUEUED_COUNT;
			cfg_q.max_queued_bytes   <= RST_MAX_QUEUED_BYTES;
			cfg_q.max_active_bytes   <= RST_MAX_ACTIVE_BYTES;
			cfg_q.max_response_bytes <= RST_MAX_RESPONSE_BYTES;
		end else if (wr_beat) begin
			unique case (reg_idx)
				REG_MAX_REQUEST_BYTES:  cfg_q.max_request_bytes  <= pwdata;
				REG_MAX_QUEUED_COUNT:   cfg_q.max_queued_count   <= pwdata;
				REG_MAX_QUEUED_BYTES:   cfg_q.max_queued_bytes   <= pwdata;
				REG_MAX_ACTIVE_BYTES:   cfg_q.max_active_bytes   <= pwdata;
				REG_MAX_RESPONSE_BYTES: cfg_q.max_response_bytes <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_MAX_REQUEST_BYTES:  prdata = cfg_q.max_request_bytes;
			REG_MAX_QUEUED_COUNT:   prdata = cfg_q.max_queued_count;
			REG_MAX_QUEUED_BYTES:   prdata = cfg_q.max_queued_bytes;
			REG_MAX_ACTIVE_BYTES:   prdata = cfg_q.max_active_bytes;
			REG_MAX_RESPONSE_BYTES: prdata = cfg_q.max_response_bytes;
			default:                prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/cac_front.sv
// front end: accepts request beats and classifies them into operations
`default_nettype none

module cac_front (
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [3:0]                   req_type,
	input  wire logic [cac_pkg::CHARGE_W-1:0] charge,
	input  wire logic [1:0]                   request_state,
	input  wire logic                         count_completion,
	input  wire logic                         cancel_flag,
	input  wire logic [4:0]                   stat_index,
	input  cac_pkg::cfg_t                     cfg,
	input  wire logic                         queue_full,
	output logic                              push,
	output cac_pkg::item_t                    item
);
	import cac_pkg::*;

	logic charge_zero;

	assign req_ready   = !queue_full;
	assign push        = req_valid;
	assign charge_zero = (charge == '0);

	// state-independent checks and operation decode
	always_comb begin
		item.charge       = charge;
		item.echo_state   = (request_state == RS_UNUSED) ? RS_NONE : request_state;
		item.from_queued  = (request_state == RS_QUEUED);
		item.completion   = count_completion;
		item.cancel       = cancel_flag;
		item.stat_index   = stat_index;
		item.req_too_big  = (charge > cfg.max_request_bytes);
		item.resp_too_big = (charge > cfg.max_response_bytes);
		unique case (req_type)
			REQ_RESERVE_Q:     item.op = charge_zero ? OP_INVALID : OP_RESERVE_Q;
			REQ_RELEASE_UNPUB: item.op = charge_zero ? OP_NOP : OP_RELEASE_UNPUB;
			REQ_ACTIVATE:
				item.op = (request_state == RS_QUEUED) ? OP_ACTIVATE : OP_INVALID;
			REQ_REQUEUE:
				item.op = (request_state == RS_ACTIVE) ? OP_REQUEUE : OP_INVALID;
			REQ_RELEASE:
				item.op = (request_state == RS_NONE) ? OP_INVALID : OP_RELEASE_REQ;
			REQ_RESERVE_RESP:  item.op = charge_zero ? OP_NOP : OP_RESERVE_RESP;
			REQ_RELEASE_RESP:  item.op = charge_zero ? OP_NOP : OP_RELEASE_RESP;
			REQ_RATE_LIMIT:    item.op = OP_RATE_LIMIT;
			REQ_READ_STAT:
				item.op = (stat_index <= STAT_EV_LAST) ? OP_READ_STAT : OP_INVALID;
			default:           item.op = OP_INVALID;
		endcase
	end

endmodule

`default_nettype wire

### hdl/cac_queue.sv
// small fifo of classified operations between front and back
`default_nettype none

module cac_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  cac_pkg::item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output cac_pkg::item_t head,
	output logic           empty
);
	import cac_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            items_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = items_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			items_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### hdl/cac_back.sv
// back end: credit levels, high-water marks, event counters and result register
`default_nettype none

module cac_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  cac_pkg::cfg_t                   cfg,
	input  cac_pkg::item_t                  head,
	input  wire logic                       empty,
	output logic                            pop,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output logic [1:0]                      status,
	output logic [1:0]                      new_request_state,
	output logic [cac_pkg::STAT_W-1:0]      stat_value
);
	import cac_pkg::*;

	// levels and marks
	logic [COUNT_W-1:0] qcount_q, acount_q, hw_qcount_q, hw_acount_q;
	logic [LEVEL_W-1:0] qbytes_q, abytes_q, rbytes_q;
	logic [LEVEL_W-1:0] hw_qbytes_q, hw_abytes_q, hw_rbytes_q;
	logic [STAT_W-1:0]  ev_q [EV_COUNT];

	// next values
	logic [COUNT_W-1:0] qcount_d, acount_d;
	logic [LEVEL_W-1:0] qbytes_d, abytes_d, rbytes_d;
	logic               mark_qcount, mark_qbytes, mark_acount, mark_abytes, mark_rbytes;
	logic [EV_COUNT-1:0] ev_bump;
	logic [1:0]          status_d, nstate_d;
	logic [STAT_W-1:0]   value_d;

	// arithmetic
	logic [LEVEL_W:0]   c_ext;
	logic [LEVEL_W:0]   qbytes_sum, abytes_sum, rbytes_sum;
	logic [LEVEL_W:0]   qbytes_dif, abytes_dif, rbytes_dif;
	logic [LEVEL_W-1:0] qbytes_add, abytes_add, rbytes_add;
	logic [LEVEL_W-1:0] qbytes_drop, abytes_drop, rbytes_drop;
	logic [COUNT_W-1:0] qcount_inc, qcount_dec, acount_inc, acount_dec;
	logic               qcount_full, qbytes_over, abytes_over;
	logic [4:0]         ev_off;
	logic [3:0]         ev_idx;

	logic rsp_valid_q;
	logic take;

	assign take      = !empty && (!rsp_valid_q || rsp_ready);
	assign pop       = take;
	assign rsp_valid = rsp_valid_q;

	// saturating adds; a subtract that would underflow leaves the level or count unchanged
	always_comb begin
		c_ext       = {{(LEVEL_W + 1 - CHARGE_W){1'b0}}, head.charge};
		qbytes_sum  = {1'b0, qbytes_q} + c_ext;
		abytes_sum  = {1'b0, abytes_q} + c_ext;
		rbytes_sum  = {1'b0, rbytes_q} + c_ext;
		qbytes_dif  = {1'b0, qbytes_q} - c_ext;
		abytes_dif  = {1'b0, abytes_q} - c_ext;
		rbytes_dif  = {1'b0, rbytes_q} - c_ext;
		qbytes_add  = qbytes_sum[LEVEL_W] ? '1 : qbytes_sum[LEVEL_W-1:0];
		abytes_add  = abytes_sum[LEVEL_W] ? '1 : abytes_sum[LEVEL_W-1:0];
		rbytes_add  = rbytes_sum[LEVEL_W] ? '1 : rbytes_sum[LEVEL_W-1:0];
		qbytes_drop = qbytes_dif[LEVEL_W] ? qbytes_q : qbytes_dif[LEVEL_W-1:0];
		abytes_drop = abytes_dif[LEVEL_W] ? abytes_q : abytes_dif[LEVEL_W-1:0];
		rbytes_drop = rbytes_dif[LEVEL_W] ? rbytes_q : rbytes_dif[LEVEL_W-1:0];
		qcount_inc  = (qcount_q == '1) ? qcount_q : qcount_q + 1'b1;
		acount_inc  = (acount_q == '1) ? acount_q : acount_q + 1'b1;
		qcount_dec  = (qcount_q == '0) ? qcount_q : qcount_q - 1'b1;
		acount_dec  = (acount_q == '0) ? acount_q : acount_q - 1'b1;
		// level plus charge above limit covers a level already over its limit,
		// a zero charge always fits
		qcount_full = (qcount_q >= cfg.max_queued_count);
		qbytes_over = (qbytes_sum > {{(LEVEL_W + 1 - CFG_W){1'b0}}, cfg.max_queued_bytes});
		abytes_over = (abytes_sum > {{(LEVEL_W + 1 - CFG_W){1'b0}}, cfg.max_active_bytes})
			&& (head.charge != '0);
		ev_off      = head.stat_index - STAT_EV_FIRST;
		ev_idx      = ev_off[3:0];
	end

	// operation execute
	always_comb begin
		qcount_d    = qcount_q;
		qbytes_d    = qbytes_q;
		acount_d    = acount_q;
		abytes_d    = abytes_q;
		rbytes_d    = rbytes_q;
		mark_qcount = 1'b0;
		mark_qbytes = 1'b0;
		mark_acount = 1'b0;
		mark_abytes = 1'b0;
		mark_rbytes = 1'b0;
		ev_bump     = '0;
		status_d    = ST_OK;
		nstate_d    = head.echo_state;
		value_d     = '0;
		unique case (head.op)
			OP_INVALID: begin
				status_d = ST_INVALID;
			end
			OP_NOP: ;
			OP_RESERVE_Q: begin
				if (head.req_too_big) begin
					ev_bump[EV_REJ_REQ]   = 1'b1;
					ev_bump[EV_ADMIT_REJ] = 1'b1;
					status_d = ST_LIMIT;
				end else if (qcount_full) begin
					ev_bump[EV_REJ_QCOUNT] = 1'b1;
					ev_bump[EV_ADMIT_REJ]  = 1'b1;
					status_d = ST_LIMIT;
				end else if (qbytes_over) begin
					ev_bump[EV_REJ_QBYTES] = 1'b1;
					ev_bump[EV_ADMIT_REJ]  = 1'b1;
					status_d = ST_LIMIT;
				end else begin
					qcount_d    = qcount_inc;
					qbytes_d    = qbytes_add;
					mark_qcount = 1'b1;
					mark_qbytes = 1'b1;
					nstate_d    = RS_QUEUED;
				end
			end
			OP_RELEASE_UNPUB: begin
				qcount_d = qcount_dec;
				qbytes_d = qbytes_drop;
			end
			OP_ACTIVATE: begin
				if (abytes_over) begin
					ev_bump[EV_REJ_ACTIVE] = 1'b1;
					status_d = ST_LIMIT;
				end else begin
					qcount_d    = qcount_dec;
					qbytes_d    = qbytes_drop;
					acount_d    = acount_inc;
					abytes_d    = abytes_add;
					mark_acount = 1'b1;
					mark_abytes = 1'b1;
					nstate_d    = RS_ACTIVE;
				end
			end
			OP_REQUEUE: begin
				acount_d = acount_dec;
				abytes_d = abytes_drop;
				qcount_d = qcount_inc;
				qbytes_d = qbytes_add;
				ev_bump[EV_RETRIED] = 1'b1;
				nstate_d = RS_QUEUED;
			end
			OP_RELEASE_REQ: begin
				if (head.from_queued) begin
					qcount_d = qcount_dec;
					qbytes_d = qbytes_drop;
				end else begin
					acount_d = acount_dec;
					abytes_d = abytes_drop;
				end
				ev_bump[EV_COMPLETED] = head.completion;
				ev_bump[EV_CANCELED]  = head.completion && head.cancel;
				nstate_d = RS_NONE;
			end
			OP_RESERVE_RESP: begin
				if (head.resp_too_big || abytes_over) begin
					ev_bump[EV_REJ_RESP] = 1'b1;
					status_d = ST_LIMIT;
				end else begin
					rbytes_d    = rbytes_add;
					abytes_d    = abytes_add;
					mark_rbytes = 1'b1;
					mark_abytes = 1'b1;
				end
			end
			OP_RELEASE_RESP: begin
				rbytes_d = rbytes_drop;
				abytes_d = abytes_drop;
			end
			OP_RATE_LIMIT: begin
				ev_bump[EV_RATE_LIMITED] = 1'b1;
			end
			OP_READ_STAT: begin
				case (head.stat_index)
					STAT_QCOUNT:    value_d = STAT_W'(qcount_q);
					STAT_QBYTES:    value_d = STAT_W'(qbytes_q);
					STAT_ACOUNT:    value_d = STAT_W'(acount_q);
					STAT_ABYTES:    value_d = STAT_W'(abytes_q);
					STAT_RBYTES:    value_d = STAT_W'(rbytes_q);
					STAT_HW_QCOUNT: value_d = STAT_W'(hw_qcount_q);
					STAT_HW_QBYTES: value_d = STAT_W'(hw_qbytes_q);
					STAT_HW_ACOUNT: value_d = STAT_W'(hw_acount_q);
					STAT_HW_ABYTES: value_d = STAT_W'(hw_abytes_q);
					STAT_HW_RBYTES: value_d = STAT_W'(hw_rbytes_q);
					default:        value_d = ev_q[ev_idx];
				endcase
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
	end

	// levels and high-water marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q    <= '0;
			qbytes_q    <= '0;
			acount_q    <= '0;
			abytes_q    <= '0;
			rbytes_q    <= '0;
			hw_qcount_q <= '0;
			hw_qbytes_q <= '0;
			hw_acount_q <= '0;
			hw_abytes_q <= '0;
			hw_rbytes_q <= '0;
		end else if (take) begin
			qcount_q <= qcount_d;
			qbytes_q <= qbytes_d;
			acount_q <= acount_d;
			abytes_q <= abytes_d;
			rbytes_q <= rbytes_d;
			if (mark_qcount && qcount_inc > hw_qcount_q) begin
				hw_qcount_q <= qcount_inc;
			end
			if (mark_qbytes && qbytes_add > hw_qbytes_q) begin
				hw_qbytes_q <= qbytes_add;
			end
			if (mark_acount && acount_inc > hw_acount_q) begin
				hw_acount_q <= acount_inc;
			end
			if (mark_abytes && abytes_add > hw_abytes_q) begin
				hw_abytes_q <= abytes_add;
			end
			if (mark_rbytes && rbytes_add > hw_rbytes_q) begin
				hw_rbytes_q <= rbytes_add;
			end
		end
	end

	// saturating event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EV_COUNT; i++) begin
				ev_q[i] <= '0;
			end
		end else if (take) begin
			for (int i = 0; i < EV_COUNT; i++) begin
				if (ev_bump[i] && ev_q[i] != '1) begin
					ev_q[i] <= ev_q[i] + 1'b1;
				end
			end
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			status            <= status_d;
			new_request_state <= nstate_d;
			stat_value        <= value_d;
		end
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for the credit admission controller: every result beat checked against a local model
`default_nettype none

module tb_top;
	import cac_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP = 18;
	localparam int LIVE_CAP = 48;
	localparam int RSP_HOLD = 300;

	// request types the block does not know
	localparam logic [3:0] REQ_UNKNOWN_FIRST = 4'd9;
	localparam logic [3:0] REQ_UNKNOWN_LAST  = 4'd15;

	// high-water mark slots
	localparam int HW_QCOUNT = 0;
	localparam int HW_QBYTES = 1;
	localparam int HW_ACOUNT = 2;
	localparam int HW_ABYTES = 3;
	localparam int HW_RBYTES = 4;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  nstate;
		logic [63:0] value;
	} answer_t;

	typedef struct packed {
		logic [31:0] amount;
		logic [1:0]  where;
	} live_req_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [CFG_W-1:0]    pwdata = '0;
	logic [CFG_W-1:0]    prdata;
	logic                pready;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [3:0]          req_type = '0;
	logic [CHARGE_W-1:0] charge = '0;
	logic [1:0]          request_state = '0;
	logic                count_completion = 1'b0;
	logic                cancel_flag = 1'b0;
	logic [4:0]          stat_index = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic [1:0]          status;
	logic [1:0]          new_request_state;
	logic [STAT_W-1:0]   stat_value;

	// model of the admission state
	logic [31:0] lim_req_bytes, lim_q_count, lim_q_bytes, lim_active_bytes, lim_resp_bytes;
	logic [31:0] q_count, a_count;
	logic [39:0] q_bytes, a_bytes, r_bytes;
	logic [39:0] hw_mark [5];
	logic [63:0] ev_count [EV_COUNT];

	answer_t   pending_answers [$];
	live_req_t held_reqs [$];
	logic [31:0] held_resps [$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  send_quiet = 0;
	int  recv_quiet = 0;
	int  rsp_hold_cycles = 0;
	bit  sender_rush = 1'b0;

	credit_admission_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.req_type         (req_type),
		.charge           (charge),
		.request_state    (request_state),
		.count_completion (count_completion),
		.cancel_flag      (cancel_flag),
		.stat_index       (stat_index),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.status           (status),
		.new_request_state(new_request_state),
		.stat_value       (stat_value)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("credit_admission_controller: mismatch");
			$finish;
		end
	end

	function automatic void restore_model();
		lim_req_bytes = RST_MAX_REQUEST_BYTES;
		lim_q_count = RST_MAX_QUEUED_COUNT;
		lim_q_bytes = RST_MAX_QUEUED_BYTES;
		lim_active_bytes = RST_MAX_ACTIVE_BYTES;
		lim_resp_bytes = RST_MAX_RESPONSE_BYTES;
		q_count = '0;
		a_count = '0;
		q_bytes = '0;
		a_bytes = '0;
		r_bytes = '0;
		for (int i = 0; i < 5; i++) hw_mark[i] = '0;
		for (int i = 0; i < EV_COUNT; i++) ev_count[i] = '0;
	endfunction

	function automatic void count_event(input int idx);
		if (ev_count[idx] != '1) ev_count[idx] = ev_count[idx] + 64'd1;
	endfunction

	function automatic void raise_mark(input int idx, input logic [39:0] v);
		if (v > hw_mark[idx]) hw_mark[idx] = v;
	endfunction

	function automatic logic [31:0] inc_count(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [39:0] add_level(input logic [39:0] lvl, input logic [31:0] c);
		logic [40:0] s;
		s = {1'b0, lvl} + {9'd0, c};
		return s[40] ? '1 : s[39:0];
	endfunction

	// room left under a limit, zero once the level is already past it
	function automatic logic [39:0] headroom(input logic [31:0] lim, input logic [39:0] lvl);
		return (lvl > {8'd0, lim}) ? '0 : {8'd0, lim} - lvl;
	endfunction

	function automatic void drop_queued(input logic [31:0] c);
		if (q_count != '0) q_count = q_count - 32'd1;
		if (q_bytes >= {8'd0, c}) q_bytes = q_bytes - {8'd0, c};
	endfunction

	function automatic void drop_active(input logic [31:0] c);
		if (a_count != '0) a_count = a_count - 32'd1;
		if (a_bytes >= {8'd0, c}) a_bytes = a_bytes - {8'd0, c};
	endfunction

	// expected answer for one event, updating the model
	function automatic answer_t admit_event(input logic [3:0] t, input logic [31:0] c,
		input logic [1:0] rs, input logic comp, input logic canc, input logic [4:0] si);
		answer_t a;
		a.status = ST_OK;
		a.nstate = (rs == RS_UNUSED) ? RS_NONE : rs;
		a.value = '0;
		case (t)
		REQ_RESERVE_Q: begin
			if (c == '0) begin
				a.status = ST_INVALID;
			end else if (c > lim_req_bytes) begin
				count_event(EV_REJ_REQ);
				a.status = ST_LIMIT;
			end else if (q_count >= lim_q_count) begin
				count_event(EV_REJ_QCOUNT);
				a.status = ST_LIMIT;
			end else if ({8'd0, c} > headroom(lim_q_bytes, q_bytes)) begin
				count_event(EV_REJ_QBYTES);
				a.status = ST_LIMIT;
			end
			if (a.status == ST_LIMIT) begin
				count_event(EV_ADMIT_REJ);
			end else if (a.status == ST_OK) begin
				q_count = inc_count(q_count);
				q_bytes = add_level(q_bytes, c);
				raise_mark(HW_QCOUNT, {8'd0, q_count});
				raise_mark(HW_QBYTES, q_bytes);
				a.nstate = RS_QUEUED;
			end
		end
		REQ_RELEASE_UNPUB: begin
			if (c != '0) drop_queued(c);
		end
		REQ_ACTIVATE: begin
			if (rs != RS_QUEUED) begin
				a.status = ST_INVALID;
			end else if ({8'd0, c} > headroom(lim_active_bytes, a_bytes)) begin
				count_event(EV_REJ_ACTIVE);
				a.status = ST_LIMIT;
			end else begin
				drop_queued(c);
				a_count = inc_count(a_count);
				a_bytes = add_level(a_bytes, c);
				raise_mark(HW_ACOUNT, {8'd0, a_count});
				raise_mark(HW_ABYTES, a_bytes);
				a.nstate = RS_ACTIVE;
			end
		end
		REQ_REQUEUE: begin
			if (rs != RS_ACTIVE) begin
				a.status = ST_INVALID;
			end else begin
				// no limit check and no high-water update on requeue
				drop_active(c);
				q_count = inc_count(q_count);
				q_bytes = add_level(q_bytes, c);
				count_event(EV_RETRIED);
				a.nstate = RS_QUEUED;
			end
		end
		REQ_RELEASE: begin
			if (rs == RS_NONE) begin
				a.status = ST_INVALID;
			end else begin
				// the unused state code releases like an active request
				if (rs == RS_QUEUED) drop_queued(c);
				else drop_active(c);
				if (comp) begin
					count_event(EV_COMPLETED);
					if (canc) count_event(EV_CANCELED);
				end
				a.nstate = RS_NONE;
			end
		end
		REQ_RESERVE_RESP: begin
			if (c != '0) begin
				if (c > lim_resp_bytes || {8'd0, c} > headroom(lim_active_bytes, a_bytes)) begin
					count_event(EV_REJ_RESP);
					a.status = ST_LIMIT;
				end else begin
					r_bytes = add_level(r_bytes, c);
					a_bytes = add_level(a_bytes, c);
					raise_mark(HW_RBYTES, r_bytes);
					raise_mark(HW_ABYTES, a_bytes);
				end
			end
		end
		REQ_RELEASE_RESP: begin
			if (c != '0) begin
				if (r_bytes >= {8'd0, c}) r_bytes = r_bytes - {8'd0, c};
				if (a_bytes >= {8'd0, c}) a_bytes = a_bytes - {8'd0, c};
			end
		end
		REQ_RATE_LIMIT: begin
			count_event(EV_RATE_LIMITED);
		end
		REQ_READ_STAT: begin
			case (si)
			STAT_QCOUNT: a.value = {32'd0, q_count};
			STAT_QBYTES: a.value = {24'd0, q_bytes};
			STAT_ACOUNT: a.value = {32'd0, a_count};
			STAT_ABYTES: a.value = {24'd0, a_bytes};
			STAT_RBYTES: a.value = {24'd0, r_bytes};
			default: begin
				if (si <= STAT_HW_RBYTES) a.value = {24'd0, hw_mark[si - STAT_HW_QCOUNT]};
				else if (si <= STAT_EV_LAST) a.value = ev_count[si - STAT_EV_FIRST];
				else a.status = ST_INVALID;
			end
			endcase
		end
		default: begin
			a.status = ST_INVALID;
		end
		endcase
		return a;
	endfunction

	// idle cycles before a beat, with quiet stretches of back-to-back traffic
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, MAX_GAP);
	endfunction

	function automatic logic [31:0] rand_charge();
		case ($urandom_range(0, 15))
		0: return '0;
		1: return '1;
		2: return $urandom;
		3, 4, 5: return $urandom_range(1, 64);
		default: return $urandom_range(1, 4096);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 4))
		0: return $urandom;
		1: return $urandom_range(0, 64);
		2: return $urandom_range(64, 65536);
		3: return '1;
		default: return $urandom_range(0, 1 << 24);
		endcase
	endfunction

	// offer one event beat and predict its answer once taken
	task automatic send_beat(input logic [3:0] t, input logic [31:0] c, input logic [1:0] rs,
		input logic comp, input logic canc, input logic [4:0] si,
		output logic [1:0] st, output logic [1:0] ns);
		int gap;
		logic took;
		answer_t a;
		gap = sender_rush ? 0 : draw_gap(send_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= t;
		charge <= c;
		request_state <= rs;
		count_completion <= comp;
		cancel_flag <= canc;
		stat_index <= si;
		do begin
			@(negedge clk);
			took = req_ready;
			@(posedge clk);
		end while (!took);
		a = admit_event(t, c, rs, comp, canc, si);
		pending_answers.push_back(a);
		st = a.status;
		ns = a.nstate;
	endtask

	// stop offering and wait until every answer is back
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		logic took;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			took = pready;
			@(posedge clk);
		end while (!took);
		case (idx)
		REG_MAX_REQUEST_BYTES:  lim_req_bytes = val;
		REG_MAX_QUEUED_COUNT:   lim_q_count = val;
		REG_MAX_QUEUED_BYTES:   lim_q_bytes = val;
		REG_MAX_ACTIVE_BYTES:   lim_active_bytes = val;
		REG_MAX_RESPONSE_BYTES: lim_resp_bytes = val;
		default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_limits(input logic [31:0] req_b, input logic [31:0] q_cnt,
		input logic [31:0] q_b, input logic [31:0] act_b, input logic [31:0] resp_b);
		wait_idle();
		write_limit(REG_MAX_REQUEST_BYTES, req_b);
		write_limit(REG_MAX_QUEUED_COUNT, q_cnt);
		write_limit(REG_MAX_QUEUED_BYTES, q_b);
		write_limit(REG_MAX_ACTIVE_BYTES, act_b);
		write_limit(REG_MAX_RESPONSE_BYTES, resp_b);
	endtask

	// one random event, mostly following the life of tracked requests
	task automatic random_event();
		int roll, idx;
		logic [3:0] op;
		logic [31:0] amt;
		logic [1:0] rs, st, ns;
		live_req_t r;
		roll = $urandom_range(0, 99);
		if (held_reqs.size() > LIVE_CAP && roll < 45) roll = 50;
		if (held_reqs.size() == 0 && roll >= 20 && roll < 60) roll = 0;
		if (roll < 20) begin
			amt = rand_charge();
			send_beat(REQ_RESERVE_Q, amt, RS_NONE, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), st, ns);
			if (st == ST_OK) held_reqs.push_back('{amount: amt, where: ns});
		end else if (roll < 60) begin
			idx = $urandom_range(0, held_reqs.size() - 1);
			r = held_reqs[idx];
			// now and then a request in the wrong state
			rs = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : r.where;
			op = (roll < 35) ? REQ_ACTIVATE : (roll < 45) ? REQ_REQUEUE : REQ_RELEASE;
			send_beat(op, r.amount, rs, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				5'($urandom_range(0, 31)), st, ns);
			if (st == ST_OK) begin
				if (ns == RS_NONE) begin
					held_reqs.delete(idx);
				end else begin
					r.where = ns;
					held_reqs[idx] = r;
				end
			end
		end else if (roll < 70) begin
			amt = rand_charge();
			send_beat(REQ_RESERVE_RESP, amt, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), st, ns);
			if (st == ST_OK && amt != '0) held_resps.push_back(amt);
		end else if (roll < 78) begin
			if (held_resps.size() != 0) begin
				idx = $urandom_range(0, held_resps.size() - 1);
				amt = held_resps[idx];
				held_resps.delete(idx);
			end else begin
				amt = rand_charge();
			end
			send_beat(REQ_RELEASE_RESP, amt, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), st, ns);
		end else if (roll < 80) begin
			send_beat(REQ_RATE_LIMIT, $urandom, 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				5'($urandom_range(0, 31)), st, ns);
		end else if (roll < 90) begin
			send_beat(REQ_READ_STAT, $urandom, 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(0, 19)), st, ns);
		end else begin
			// noise: any field value at all
			send_beat(4'($urandom_range(0, 15)), rand_charge(), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				5'($urandom_range(0, 31)), st, ns);
		end
	endtask

	task automatic test_directed_events();
		logic [1:0] st, ns;
		send_beat(REQ_RESERVE_Q, '0, RS_NONE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RESERVE_Q, '1, RS_NONE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RESERVE_Q, 32'd1000, RS_UNUSED, 1'b1, 1'b1, STAT_QCOUNT, st, ns);
		send_beat(REQ_ACTIVATE, 32'd1000, RS_NONE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_ACTIVATE, '1, RS_QUEUED, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_ACTIVATE, 32'd1000, RS_QUEUED, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RESERVE_RESP, '0, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RESERVE_RESP, '1, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RESERVE_RESP, 32'd500, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE_RESP, '0, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE_RESP, '1, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE_RESP, 32'd500, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_REQUEUE, 32'd1000, RS_QUEUED, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_REQUEUE, 32'd1000, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE, 32'd1000, RS_NONE, 1'b1, 1'b1, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE, 32'd7, RS_UNUSED, 1'b1, 1'b1, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE, 32'd1000, RS_QUEUED, 1'b1, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RELEASE_UNPUB, '0, RS_QUEUED, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		// count already at zero stays there
		send_beat(REQ_RELEASE_UNPUB, 32'd5, RS_QUEUED, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_RATE_LIMIT, '0, RS_NONE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_READ_STAT, '0, RS_NONE, 1'b0, 1'b0, STAT_EV_LAST, st, ns);
		send_beat(REQ_READ_STAT, '0, RS_NONE, 1'b0, 1'b0, STAT_HW_ABYTES, st, ns);
		send_beat(REQ_READ_STAT, '1, RS_UNUSED, 1'b1, 1'b1, 5'd31, st, ns);
		send_beat(REQ_UNKNOWN_FIRST, 32'd1, RS_ACTIVE, 1'b0, 1'b0, STAT_QCOUNT, st, ns);
		send_beat(REQ_UNKNOWN_LAST, '1, RS_UNUSED, 1'b1, 1'b1, 5'd31, st, ns);
	endtask

	task automatic test_limit_extremes();
		apply_limits('0, '0, '0, '0, '0);
		repeat (60) random_event();
		apply_limits('1, '1, '1, '1, '1);
		repeat (150) random_event();
	endtask

	// small limits, with levels left from before often above them
	task automatic test_tight_limits();
		apply_limits(32'd4096, 32'd8, 32'd6000, 32'd5000, 32'd2000);
		repeat (250) random_event();
	endtask

	// results held back long enough that the block stalls its input
	task automatic test_backpressure();
		wait_idle();
		sender_rush = 1'b1;
		rsp_hold_cycles = RSP_HOLD;
		repeat (40) random_event();
		sender_rush = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_limits();
		repeat (3) begin
			apply_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit(), pick_limit());
			repeat (120) random_event();
		end
	endtask

	task automatic test_default_limits();
		apply_limits(RST_MAX_REQUEST_BYTES, RST_MAX_QUEUED_COUNT, RST_MAX_QUEUED_BYTES,
			RST_MAX_ACTIVE_BYTES, RST_MAX_RESPONSE_BYTES);
		repeat (150) random_event();
	endtask

	// result side: random stalls plus the long hold-off on request
	initial begin
		int gap;
		logic got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				gap = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				gap = draw_gap(recv_quiet);
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do begin
				@(negedge clk);
				got = rsp_valid;
				@(posedge clk);
			end while (!got);
		end
	end

	// compare each result beat with the oldest prediction
	always @(negedge clk) begin
		answer_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (pending_answers.size() == 0) begin
				$error("result beat with no prediction waiting");
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (new_request_state !== want.nstate) begin
					$error("new_request_state: expected %0d, got %0d", want.nstate,
						new_request_state);
					mismatches++;
				end
				if (stat_value !== want.value) begin
					$error("stat_value: expected %0h, got %0h", want.value, stat_value);
					mismatches++;
				end
			end
		end
	end

	// test sequence
	initial begin
		restore_model();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		test_directed_events();
		test_limit_extremes();
		test_tight_limits();
		test_backpressure();
		test_random_limits();
		test_default_limits();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("credit_admission_controller: match");
		end else begin
			$display("credit_admission_controller: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
